@@ rtl/pwtcd_pkg.sv @@
// ----------------------------------------------------------------------------
// pwtcd_pkg
// Shared types and codes of the pulse-width time code decoder.
// ----------------------------------------------------------------------------
package pwtcd_pkg;

  localparam int unsigned MS_W       = 16;
  localparam int unsigned FRAME_W    = 60;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Nominal frame length; one more second when the leap announcement is set.
  localparam logic [CNT_W-1:0] FRAME_LEN_BASE = 6'd59;
  localparam int unsigned LEAP_BIT   = 19;
  localparam int unsigned START_BIT  = 20;
  localparam int unsigned MIN_FIRST  = 21;
  localparam int unsigned MIN_COUNT  = 8;
  localparam int unsigned HOUR_FIRST = 29;
  localparam int unsigned HOUR_COUNT = 7;
  localparam int unsigned DATE_FIRST = 36;
  localparam int unsigned DATE_COUNT = 23;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER_MAX = 3'd5;

  localparam logic [MS_W-1:0] RST_ZERO_MIN   = 16'd40;
  localparam logic [MS_W-1:0] RST_ZERO_MAX   = 16'd130;
  localparam logic [MS_W-1:0] RST_ONE_MIN    = 16'd140;
  localparam logic [MS_W-1:0] RST_ONE_MAX    = 16'd250;
  localparam logic [MS_W-1:0] RST_MARKER_MIN = 16'd1500;
  localparam logic [MS_W-1:0] RST_MARKER_MAX = 16'd2200;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_ONE  = 2'd1,
    CLS_MARK = 2'd2,
    CLS_ERR  = 2'd3
  } cls_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_WAITING = 3'd0,
    ST_STARTED = 3'd1,
    ST_ERROR   = 3'd2,
    ST_BIT     = 3'd3,
    ST_SYNCED  = 3'd4,
    ST_BREAK   = 3'd5
  } status_t;

  // One classified beat on its way from the front end to the back end.
  typedef struct packed {
    cls_t cls;
    logic is_pulse;
  } q_entry_t;

  function automatic logic xor_span(input logic [FRAME_W-1:0] f,
                                    input int unsigned first,
                                    input int unsigned count);
    logic p;
    p = 1'b0;
    for (int unsigned i = 0; i < FRAME_W; i++) begin
      if (i >= first && i < first + count) p = p ^ f[i];
    end
    return p;
  endfunction

endpackage

@@ rtl/pwtcd_front.sv @@
// ----------------------------------------------------------------------------
// pwtcd_front
// Window registers and duration classifier; pushes classified beats to the
// queue.
// ----------------------------------------------------------------------------
module pwtcd_front
  import pwtcd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MS_W-1:0]      cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MS_W-1:0]      in_duration_ms,
  input  logic                 in_is_pulse,
  output logic                 q_push,
  output q_entry_t             q_wdata,
  input  logic                 q_full
);

  logic [MS_W-1:0] zero_min_r, zero_max_r, one_min_r, one_max_r;
  logic [MS_W-1:0] marker_min_r, marker_max_r;
  logic            hit_zero, hit_one, hit_mark;
  cls_t            cls;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_min_r   <= RST_ZERO_MIN;
      zero_max_r   <= RST_ZERO_MAX;
      one_min_r    <= RST_ONE_MIN;
      one_max_r    <= RST_ONE_MAX;
      marker_min_r <= RST_MARKER_MIN;
      marker_max_r <= RST_MARKER_MAX;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ZERO_MIN:   zero_min_r   <= cfg_data;
        REG_ZERO_MAX:   zero_max_r   <= cfg_data;
        REG_ONE_MIN:    one_min_r    <= cfg_data;
        REG_ONE_MAX:    one_max_r    <= cfg_data;
        REG_MARKER_MIN: marker_min_r <= cfg_data;
        REG_MARKER_MAX: marker_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign hit_zero = (in_duration_ms >= zero_min_r) && (in_duration_ms < zero_max_r);
  assign hit_one  = (in_duration_ms >= one_min_r) && (in_duration_ms < one_max_r);
  assign hit_mark = (in_duration_ms >= marker_min_r) && (in_duration_ms < marker_max_r);

  // Overlapping windows resolve in the order zero, one, marker.
  always_comb begin
    if (hit_zero)      cls = CLS_ZERO;
    else if (hit_one)  cls = CLS_ONE;
    else if (hit_mark) cls = CLS_MARK;
    else               cls = CLS_ERR;
  end

  assign in_ready         = !q_full;
  assign q_push           = in_valid && !q_full;
  assign q_wdata.cls      = cls;
  assign q_wdata.is_pulse = in_is_pulse;

endmodule

@@ rtl/pwtcd_queue.sv @@
// ----------------------------------------------------------------------------
// pwtcd_queue
// Short flop-based queue of classified beats between front and back end.
// ----------------------------------------------------------------------------
module pwtcd_queue
  import pwtcd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wdata,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output q_entry_t rdata
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(QUEUE_DEPTH);

  q_entry_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0]   count_r;
  logic                do_push, do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ rtl/pwtcd_back.sv @@
// ----------------------------------------------------------------------------
// pwtcd_back
// Frame state machine: accumulates bits, latches and checks finished frames,
// and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module pwtcd_back
  import pwtcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_not_empty,
  input  q_entry_t            q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [FRAME_W-1:0]  out_latched_frame
);

  logic                in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0]    bit_count_r, bit_count_nxt;
  logic [FRAME_W-1:0]  acc_r, acc_nxt;
  logic [FRAME_W-1:0]  done_r, done_nxt;
  logic                out_valid_r;
  status_t             status_r, status_nxt;
  logic [FRAME_W-1:0]  bit_mask;
  logic [CNT_W-1:0]    cnt_inc;
  logic [CNT_W-1:0]    frame_len;
  logic                frame_ok;

  assign q_pop = q_not_empty && (!out_valid_r || out_ready);

  assign bit_mask  = (bit_count_r < CNT_W'(FRAME_W)) ? (FRAME_W'(1) << bit_count_r) : '0;
  assign cnt_inc   = bit_count_r + 1'b1;
  assign frame_len = FRAME_LEN_BASE + CNT_W'(acc_nxt[LEAP_BIT]);
  assign frame_ok  = !acc_nxt[0] && acc_nxt[START_BIT] &&
                     !xor_span(acc_nxt, MIN_FIRST, MIN_COUNT) &&
                     !xor_span(acc_nxt, HOUR_FIRST, HOUR_COUNT) &&
                     !xor_span(acc_nxt, DATE_FIRST, DATE_COUNT);

  always_comb begin
    in_frame_nxt  = in_frame_r;
    bit_count_nxt = bit_count_r;
    acc_nxt       = acc_r;
    done_nxt      = done_r;
    status_nxt    = ST_WAITING;
    if (!in_frame_r) begin
      if (q_rdata.cls == CLS_MARK) begin
        in_frame_nxt  = 1'b1;
        bit_count_nxt = '0;
        acc_nxt       = '0;
        status_nxt    = ST_STARTED;
      end
    end else if (!q_rdata.is_pulse) begin
      status_nxt = ST_BREAK;
    end else if (q_rdata.cls == CLS_ERR || q_rdata.cls == CLS_MARK) begin
      in_frame_nxt  = 1'b0;
      bit_count_nxt = '0;
      status_nxt    = ST_ERROR;
    end else begin
      if (q_rdata.cls == CLS_ONE) acc_nxt = acc_r | bit_mask;
      bit_count_nxt = cnt_inc;
      // The frame closes after its last second; a wrapped count closes it too.
      if (cnt_inc >= frame_len || cnt_inc == '0) begin
        done_nxt      = acc_nxt;
        in_frame_nxt  = 1'b0;
        bit_count_nxt = '0;
        status_nxt    = frame_ok ? ST_SYNCED : ST_ERROR;
      end else begin
        status_nxt = ST_BIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      bit_count_r <= '0;
      acc_r       <= '0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        in_frame_r  <= in_frame_nxt;
        bit_count_r <= bit_count_nxt;
        acc_r       <= acc_nxt;
        done_r      <= done_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) status_r <= status_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_latched_frame = done_r;

endmodule

@@ rtl/pulse_width_time_code_decoder_top.sv @@
// ----------------------------------------------------------------------------
// pulse_width_time_code_decoder_top
// Pulse-width minute frame decoder: classifier, beat queue and frame engine.
// ----------------------------------------------------------------------------
// Path: an accepted input beat is classified into the queue at the accepting
// edge, and the frame engine loads it into the output register once that
// register is free or its beat is being taken.
// Throughput: one beat per cycle while out_ready stays high.
// Reset: synchronous, active low; clears the windows to their defaults, the
// frame state, the latched frame and the queue.
module pulse_width_time_code_decoder_top
  import pwtcd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MS_W-1:0]      cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MS_W-1:0]      in_duration_ms,
  input  logic                 in_is_pulse,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [FRAME_W-1:0]   out_latched_frame
);

  logic     q_push, q_full, q_pop, q_not_empty;
  q_entry_t q_wdata, q_rdata;

  pwtcd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_duration_ms (in_duration_ms),
    .in_is_pulse    (in_is_pulse),
    .q_push         (q_push),
    .q_wdata        (q_wdata),
    .q_full         (q_full)
  );

  pwtcd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  pwtcd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_not_empty       (q_not_empty),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_latched_frame (out_latched_frame)
  );

endmodule

@@ rtl/pwtcd_checker.sv @@
// ----------------------------------------------------------------------------
// pwtcd_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pwtcd_checker
  import pwtcd_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [MS_W-1:0]      cfg_data,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [MS_W-1:0]      in_duration_ms,
  input logic                 in_is_pulse,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [STATUS_W-1:0]  out_status,
  input logic [FRAME_W-1:0]   out_latched_frame
);

  // No result beat may appear in the cycle after reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  // A synced frame must carry a clean start and a zero leading second.
  a_synced_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SYNCED |->
      !out_latched_frame[0] && out_latched_frame[START_BIT])
    else $error("synced status with a frame failing the start checks");

  // A stalled result beat keeps its payload.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_latched_frame))
    else $error("stalled result beat changed");

  // Only defined status codes leave the block.
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_BREAK)
    else $error("undefined status code on a result beat");

endmodule

bind pulse_width_time_code_decoder_top pwtcd_checker u_pwtcd_checker (.*);
